// ----- hdl/bft_pkg.sv -----
package bft_pkg;

    // Sizes of the filter
    localparam int MAX_INDEX_BITS = 16;
    localparam int MAX_PROBES     = 32;
    localparam int DIGEST_BITS    = 160;

    // Field and register widths
    localparam int INDEX_BITS_W  = 5;
    localparam int PROBE_COUNT_W = 6;
    localparam int CFG_DATA_W    = 6;
    localparam int CFG_INDEX_W   = 1;
    localparam int COUNT_W       = 32;
    localparam int PRODUCT_W     = INDEX_BITS_W + PROBE_COUNT_W;

    // Bit store: packed into words, one word per memory row
    localparam int WORD_BITS  = 32;
    localparam int WORD_SEL_W = $clog2(WORD_BITS);
    localparam int STORE_ROWS = (2 ** MAX_INDEX_BITS) / WORD_BITS;
    localparam int ROW_W      = $clog2(STORE_ROWS);

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_COUNT = CFG_INDEX_W'(1);

    // Controller to datapath commands
    typedef struct packed {
        logic clear_wr;   // zero one store row
        logic load;       // capture input item
        logic rd_issue;   // read the row of the current probe
        logic eval;       // check or set the probed bit, step to next probe
        logic finish;     // move result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;  // last row being cleared
        logic no_mat;      // k*b reaches digest width
        logic is_test;
        logic probes_zero; // no probes left
        logic last_probe;  // exactly one probe left
        logic miss;        // probed bit reads zero (valid during eval)
        logic out_free;    // output register can take a result
    } sts_t;

endpackage

// ----- hdl/bft_ram.sv -----
module bft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- hdl/bft_ctrl.sv -----
module bft_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bft_pkg::sts_t sts,
    output bft_pkg::cmd_t cmd
);
    import bft_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.no_mat || sts.probes_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                // a test stops at the first clear bit
                if ((sts.is_test && sts.miss) || sts.last_probe)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Results never overwrite an untaken result
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |-> sts.out_free)
        else $error("finish while output register busy");

    // An accepted item is always checked next
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> state_reg == ST_CHECK)
        else $error("load not followed by check");

    // Evaluation always follows a read of the same probe
    assert property (@(posedge clk) disable iff (!rst_n) cmd.eval |-> $past(cmd.rd_issue))
        else $error("eval without preceding read");

endmodule

// ----- hdl/bft_datapath.sv -----
module bft_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bft_pkg::cmd_t                     cmd,
    output bft_pkg::sts_t                     sts,
    input  logic                              cfg_write_en,
    input  logic [bft_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bft_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              operation,
    input  logic [63:0]                       digest_high,
    input  logic [63:0]                       digest_mid,
    input  logic [31:0]                       digest_low,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic                              no_material,
    output logic [bft_pkg::COUNT_W-1:0]       insert_count
);
    import bft_pkg::*;

    logic [INDEX_BITS_W-1:0]  index_bits_reg;
    logic [PROBE_COUNT_W-1:0] probe_count_reg;
    logic [INDEX_BITS_W-1:0]  b_eff;
    logic [PROBE_COUNT_W-1:0] k_eff;
    logic [PRODUCT_W-1:0]     kb;

    logic [DIGEST_BITS-1:0]   digest_reg;
    logic [PROBE_COUNT_W-1:0] remain_reg;
    logic                     op_reg;
    logic                     nomat_reg;
    logic                     hit_reg;
    logic [COUNT_W-1:0]       cnt_reg;
    logic [COUNT_W-1:0]       cnt_next;
    logic [ROW_W-1:0]         clr_row_reg;

    logic                     out_valid_reg;
    logic                     out_hit_reg;
    logic                     out_nomat_reg;
    logic [COUNT_W-1:0]       out_count_reg;

    logic [MAX_INDEX_BITS-1:0] probe_idx;
    logic [ROW_W-1:0]          probe_row;
    logic [WORD_SEL_W-1:0]     probe_sel;
    logic [INDEX_BITS_W-1:0]   idx_shift;

    logic                     ram_we;
    logic                     ram_re;
    logic [ROW_W-1:0]         ram_addr;
    logic [WORD_BITS-1:0]     ram_wdata;
    logic [WORD_BITS-1:0]     ram_rdata;
    logic                     add_ok;
    logic                     out_take;

    // Configuration registers, saturated on use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg  <= INDEX_BITS_W'(10);
            probe_count_reg <= PROBE_COUNT_W'(3);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_INDEX_BITS:  index_bits_reg  <= cfg_data[INDEX_BITS_W-1:0];
                REG_PROBE_COUNT: probe_count_reg <= cfg_data[PROBE_COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign b_eff = (index_bits_reg > INDEX_BITS_W'(MAX_INDEX_BITS))
                   ? INDEX_BITS_W'(MAX_INDEX_BITS) : index_bits_reg;
    assign k_eff = (probe_count_reg > PROBE_COUNT_W'(MAX_PROBES))
                   ? PROBE_COUNT_W'(MAX_PROBES) : probe_count_reg;
    assign kb    = PRODUCT_W'(k_eff) * PRODUCT_W'(b_eff);

    // Current probe index: top b bits of the shifted digest
    assign idx_shift = INDEX_BITS_W'(MAX_INDEX_BITS) - b_eff;
    assign probe_idx = digest_reg[DIGEST_BITS-1 -: MAX_INDEX_BITS] >> idx_shift;
    assign probe_row = probe_idx[MAX_INDEX_BITS-1:WORD_SEL_W];
    assign probe_sel = probe_idx[WORD_SEL_W-1:0];

    // Item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            digest_reg <= {digest_high, digest_mid, digest_low};
            op_reg     <= operation;
            nomat_reg  <= (kb >= PRODUCT_W'(DIGEST_BITS));
        end
        else if (cmd.eval)
        begin
            digest_reg <= digest_reg << b_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.load)
        begin
            remain_reg <= k_eff;
            hit_reg    <= 1'b1;
        end
        else if (cmd.eval)
        begin
            remain_reg <= remain_reg - PROBE_COUNT_W'(1);
            if (op_reg == OP_TEST && sts.miss)
            begin
                hit_reg <= 1'b0;
            end
        end
    end

    // Clearing pass row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_row_reg <= clr_row_reg + ROW_W'(1);
        end
    end

    // Bit store access: clear, read, read-modify-write for add
    assign ram_we    = cmd.clear_wr || (cmd.eval && op_reg == OP_ADD);
    assign ram_re    = cmd.rd_issue;
    assign ram_addr  = cmd.clear_wr ? clr_row_reg : probe_row;
    assign ram_wdata = cmd.clear_wr ? '0
                       : (ram_rdata | (WORD_BITS'(1) << probe_sel));

    bft_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Insert counter and output register
    assign add_ok   = (op_reg == OP_ADD) && !nomat_reg;
    assign cnt_next = cnt_reg + COUNT_W'(add_ok);
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_hit_reg   <= hit_reg && !nomat_reg;
            out_nomat_reg <= nomat_reg;
            out_count_reg <= cnt_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign no_material  = out_nomat_reg;
    assign insert_count = out_count_reg;

    // Status
    assign sts.clear_last  = (clr_row_reg == ROW_W'(STORE_ROWS - 1));
    assign sts.no_mat      = nomat_reg;
    assign sts.is_test     = (op_reg == OP_TEST);
    assign sts.probes_zero = (remain_reg == '0);
    assign sts.last_probe  = (remain_reg == PROBE_COUNT_W'(1));
    assign sts.miss        = !ram_rdata[probe_sel];
    assign sts.out_free    = !out_valid_reg || !out_stall;

    // A probe is never evaluated with none left
    assert property (@(posedge clk) disable iff (!rst_n) cmd.eval |-> remain_reg != '0)
        else $error("probe evaluated with count exhausted");

    // Output valid only rises from a finished item
    assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("output valid without finish");

    // Insert counter moves only when a result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |-> $past(cmd.finish))
        else $error("insert counter changed outside finish");

endmodule

// ----- hdl/bloom_filter_insert_test_core.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_stall    operation, digest_high, digest_mid, digest_low
// output    out_valid / out_stall  hit, no_material, insert_count
// config    cfg_write_en           cfg_index, cfg_data
//
// For k probes, each probe reads one store word and then checks or sets
// it through the single port of the store, so the memory port sets the
// pace. A test ends at its first clear bit.
// After reset a clearing pass zeroes the store one 32-bit row a cycle,
// with in_stall high; configuration writes are taken meanwhile.
// The result sits in an output register, so a new item is accepted while
// out_stall holds the previous result.
module bloom_filter_insert_test_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [bft_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bft_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [63:0]                       digest_high,
    input  logic [63:0]                       digest_mid,
    input  logic [31:0]                       digest_low,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic                              no_material,
    output logic [bft_pkg::COUNT_W-1:0]       insert_count
);
    import bft_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    bft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store, probe extraction, counter and result register
    bft_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .digest_high  (digest_high),
        .digest_mid   (digest_mid),
        .digest_low   (digest_low),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .no_material  (no_material),
        .insert_count (insert_count)
    );

endmodule
